// ----- rtl/core/vcdt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcdt_pkg: shared types, constants and microcode for the delay tracker
// Holds the control word layout, the condition and micro-op codes, the
// register indexes of the configuration port and the microcode program.
// ----------------------------------------------------------------------------
package vcdt_pkg;

  // default nanoseconds per microsecond
  localparam int unsigned NS_PER_US_DEFAULT = 1000;

  // field widths fixed by the interface
  localparam int unsigned TIME_W    = 63;
  localparam int unsigned AMOUNT_W  = 32;
  localparam int unsigned RATIO_W   = 32;
  localparam int unsigned CFG_US_W  = 16;
  localparam int unsigned PROD_W    = AMOUNT_W + RATIO_W;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned SCALED_W  = PROD_W - FRAC_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(32'h0001_0000);
  localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRECISION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_RATIO = 2'd2;

  // micro-ops driving the datapath
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_MOD_INIT,
    OP_MOD_STEP,
    OP_ROUND_BASE,
    OP_ROUND_ADD,
    OP_NO_ROUND,
    OP_ADD_FREE,
    OP_TIME_UPD,
    OP_BUILT,
    OP_REPORT
  } uop_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_FUNC0,
    COND_NO_PREC,
    COND_CNT_NZ,
    COND_OUT_BUSY
  } cond_e;

  typedef logic [3:0] step_t;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    step_t jmp;
    step_t nxt;
  } ctl_word_t;

  // program addresses
  localparam step_t STEP_WAIT       = 4'd0;
  localparam step_t STEP_MUL        = 4'd1;
  localparam step_t STEP_MOD_INIT   = 4'd2;
  localparam step_t STEP_MOD_STEP   = 4'd3;
  localparam step_t STEP_ROUND_BASE = 4'd4;
  localparam step_t STEP_ROUND_ADD  = 4'd5;
  localparam step_t STEP_NO_ROUND   = 4'd6;
  localparam step_t STEP_ADD_FREE   = 4'd7;
  localparam step_t STEP_TIME_UPD   = 4'd8;
  localparam step_t STEP_BUILT      = 4'd9;
  localparam step_t STEP_REPORT     = 4'd10;

  // microcode read-only table
  function automatic ctl_word_t ucode_rom(step_t addr);
    ctl_word_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, jmp: STEP_WAIT, nxt: STEP_WAIT};
    unique case (addr)
      STEP_WAIT:
        w = '{op: OP_LOAD, cond: COND_NO_IN, jmp: STEP_WAIT, nxt: STEP_MUL};
      STEP_MUL:
        w = '{op: OP_MUL, cond: COND_FUNC0, jmp: STEP_TIME_UPD, nxt: STEP_MOD_INIT};
      STEP_MOD_INIT:
        w = '{op: OP_MOD_INIT, cond: COND_NO_PREC, jmp: STEP_NO_ROUND,
              nxt: STEP_MOD_STEP};
      STEP_MOD_STEP:
        w = '{op: OP_MOD_STEP, cond: COND_CNT_NZ, jmp: STEP_MOD_STEP,
              nxt: STEP_ROUND_BASE};
      STEP_ROUND_BASE:
        w = '{op: OP_ROUND_BASE, cond: COND_NEVER, jmp: STEP_WAIT,
              nxt: STEP_ROUND_ADD};
      STEP_ROUND_ADD:
        w = '{op: OP_ROUND_ADD, cond: COND_NEVER, jmp: STEP_WAIT,
              nxt: STEP_ADD_FREE};
      STEP_NO_ROUND:
        w = '{op: OP_NO_ROUND, cond: COND_NEVER, jmp: STEP_WAIT,
              nxt: STEP_ADD_FREE};
      STEP_ADD_FREE:
        w = '{op: OP_ADD_FREE, cond: COND_NEVER, jmp: STEP_WAIT, nxt: STEP_BUILT};
      STEP_TIME_UPD:
        w = '{op: OP_TIME_UPD, cond: COND_NEVER, jmp: STEP_WAIT, nxt: STEP_BUILT};
      STEP_BUILT:
        w = '{op: OP_BUILT, cond: COND_NEVER, jmp: STEP_WAIT, nxt: STEP_REPORT};
      STEP_REPORT:
        w = '{op: OP_REPORT, cond: COND_OUT_BUSY, jmp: STEP_REPORT,
              nxt: STEP_WAIT};
      default:
        w = '{op: OP_NOP, cond: COND_ALWAYS, jmp: STEP_WAIT, nxt: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/virtual_cpu_delay_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_cpu_delay_tracker_unit: delay bookkeeping for a simulated CPU
// Keeps current time and CPU free time, scales and rounds measured delays
// and reports the delay ahead of the current time when above threshold.
// ----------------------------------------------------------------------------
// Each input word produces exactly one output word. A time update and an
// add-delay word with rounding off skip the remainder loop; with rounding
// on, the rounding remainder is found by a bit-serial restoring modulo that
// retires one bit of the 48-bit scaled delay per cycle. A microcode table
// with a step counter sequences a 32x32 multiplier, the remainder loop and
// the 63-bit time adders. The result sits in an output register, so the
// next input word is taken while the previous result waits; the sequencer
// holds only when a new result is ready and the output register is still
// full. Configuration writes are always accepted and are meant for idle
// periods.
// ----------------------------------------------------------------------------
module virtual_cpu_delay_tracker_unit #(
  parameter int unsigned NS_PER_US = vcdt_pkg::NS_PER_US_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [vcdt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [vcdt_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             func_i,
  input  logic [vcdt_pkg::TIME_W-1:0]      event_time_i,
  input  logic [vcdt_pkg::AMOUNT_W-1:0]    delay_amount_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [vcdt_pkg::TIME_W-1:0]      pending_delay_o,
  output logic                             blocked_o
);
  import vcdt_pkg::*;

  // nanosecond widths of the scaled configuration values
  localparam int unsigned NS_W  = CFG_US_W + $clog2(NS_PER_US + 1);
  localparam int unsigned ADD_W = ((SCALED_W > NS_W) ? SCALED_W : NS_W) + 1;
  localparam int unsigned CNT_W = $clog2(SCALED_W);

  // configuration registers, threshold and precision kept in nanoseconds
  logic [NS_W-1:0]    thr_ns_q;
  logic [NS_W-1:0]    prec_ns_q;
  logic [RATIO_W-1:0] ratio_q;

  // sequencer
  step_t     step_q, step_d;
  ctl_word_t ctl;
  logic      cond_hit;

  // latched input word
  logic                func_q;
  logic [TIME_W-1:0]   event_q;
  logic [AMOUNT_W-1:0] amount_q;

  // datapath registers
  logic [PROD_W-1:0]   prod_q;
  logic [SCALED_W-1:0] sh_q;
  logic [NS_W-1:0]     rem_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SCALED_W-1:0] base_q;
  logic                up_q;
  logic [ADD_W-1:0]    addv_q;
  logic [TIME_W-1:0]   built_q;
  logic [TIME_W-1:0]   cur_q, cur_d;
  logic [TIME_W-1:0]   free_q, free_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [TIME_W-1:0] pend_q;
  logic              blk_q;
  logic              out_busy;
  logic              out_load;

  // datapath helpers
  logic [SCALED_W-1:0] scaled;
  logic [NS_W:0]       mod_try;
  logic [TIME_W:0]     free_sum;
  logic                over_thr;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_ns_q  <= '0;
      prec_ns_q <= '0;
      ratio_q   <= RATIO_ONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_THRESHOLD:  thr_ns_q  <= NS_W'(cfg_data_i[CFG_US_W-1:0]) * NS_W'(NS_PER_US);
        REG_PRECISION:  prec_ns_q <= NS_W'(cfg_data_i[CFG_US_W-1:0]) * NS_W'(NS_PER_US);
        REG_FREQ_RATIO: ratio_q   <= cfg_data_i[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // microcode fetch and jump condition
  assign ctl        = ucode_rom(step_q);
  assign out_busy   = out_valid_q & ~out_ready_i;
  assign in_ready_o = (ctl.op == OP_LOAD);

  always_comb begin
    unique case (ctl.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_NO_IN:    cond_hit = ~in_valid_i;
      COND_FUNC0:    cond_hit = ~func_q;
      COND_NO_PREC:  cond_hit = (prec_ns_q == '0);
      COND_CNT_NZ:   cond_hit = (cnt_q != '0);
      COND_OUT_BUSY: cond_hit = out_busy;
      default:       cond_hit = 1'b0;
    endcase
    step_d = cond_hit ? ctl.jmp : ctl.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  // combinational pieces of the datapath
  assign scaled   = prod_q[PROD_W-1:FRAC_W];
  assign mod_try  = {rem_q, sh_q[SCALED_W-1]};
  assign free_sum = {1'b0, free_q} + (TIME_W + 1)'(addv_q);
  assign over_thr = (thr_ns_q != '0) && (built_q > TIME_W'(thr_ns_q));
  assign out_load = (ctl.op == OP_REPORT) && !out_busy;

  // payload datapath, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (ctl.op)
      OP_LOAD: begin
        if (in_valid_i) begin
          func_q   <= func_i;
          event_q  <= event_time_i;
          amount_q <= delay_amount_i;
        end
      end
      OP_MUL: begin
        prod_q <= PROD_W'(amount_q) * PROD_W'(ratio_q);
      end
      OP_MOD_INIT: begin
        sh_q  <= scaled;
        rem_q <= '0;
        cnt_q <= CNT_W'(SCALED_W - 1);
      end
      OP_MOD_STEP: begin
        // restoring remainder step, one bit per cycle
        if (mod_try >= {1'b0, prec_ns_q}) begin
          rem_q <= NS_W'(mod_try - {1'b0, prec_ns_q});
        end else begin
          rem_q <= NS_W'(mod_try);
        end
        sh_q  <= {sh_q[SCALED_W-2:0], 1'b0};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      OP_ROUND_BASE: begin
        base_q <= scaled - SCALED_W'(rem_q);
        up_q   <= ({rem_q, 1'b0} >= {1'b0, prec_ns_q});
      end
      OP_ROUND_ADD: begin
        addv_q <= ADD_W'(base_q) + (up_q ? ADD_W'(prec_ns_q) : '0);
      end
      OP_NO_ROUND: begin
        addv_q <= ADD_W'(scaled);
      end
      OP_BUILT: begin
        built_q <= free_q - cur_q;
      end
      default: ;
    endcase
  end

  // time state update
  always_comb begin
    cur_d  = cur_q;
    free_d = free_q;
    unique case (ctl.op)
      OP_TIME_UPD: begin
        cur_d = event_q;
        if (free_q < event_q) begin
          free_d = event_q;
        end
      end
      OP_ADD_FREE: begin
        // saturate at the largest representable time
        free_d = free_sum[TIME_W] ? TIME_MAX : free_sum[TIME_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      free_q <= '0;
    end else begin
      cur_q  <= cur_d;
      free_q <= free_d;
    end
  end

  // output register
  assign out_valid_d = out_load | out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pend_q <= over_thr ? built_q : '0;
      blk_q  <= over_thr;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pending_delay_o = pend_q;
  assign blocked_o       = blk_q;

  // free time never falls behind current time
  a_free_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q >= cur_q)
    else $error("free time behind current time");

  // a new output word only comes from the report step
  a_out_from_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_q) == STEP_REPORT)
    else $error("output word raised outside report step");

  // blocked flag agrees with the reported delay
  a_blk_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (blk_q == (pend_q != '0)))
    else $error("blocked flag disagrees with pending delay");

  // the final remainder is below the rounding step when the loop ends
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_ROUND_BASE) |-> (rem_q < prec_ns_q))
    else $error("remainder not reduced below rounding step");

  // the report step holds while the output register is full
  a_stall_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_REPORT && out_busy) |=> step_q == STEP_REPORT)
    else $error("report step left while output register full");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the virtual cpu delay tracker
// Walks a directed table split around random phases under several register
// settings. Every accepted word goes through an in-bench tracker model, and
// each result word is checked against the oldest expected report.
// ----------------------------------------------------------------------------
module testbench;
  import vcdt_pkg::*;

  localparam longint unsigned NS_US = NS_PER_US_DEFAULT;
  localparam logic FN_TIME  = 1'b0;
  localparam logic FN_DELAY = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [63:0] TIME_LIMIT = {1'b0, TIME_MAX};
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 180;

  // one directed row: a register write or an input word
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    logic                 fn;
    logic [TIME_W-1:0]    evt;
    logic [AMOUNT_W-1:0]  amt;
    logic                 typed;
    logic [TIME_W-1:0]    want_pend;
    logic                 want_blk;
  } stim_row_t;

  typedef struct packed {
    logic [TIME_W-1:0] pend;
    logic              blk;
  } delay_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = FN_TIME;
  logic [TIME_W-1:0] evt_time = '0;
  logic [AMOUNT_W-1:0] delay_amt = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [TIME_W-1:0] pending_delay;
  logic blocked;

  // tracker model state and register copies
  logic [63:0] cur_ns = '0;
  logic [63:0] free_ns = '0;
  logic [CFG_US_W-1:0] thr_us = '0;
  logic [CFG_US_W-1:0] prec_us = '0;
  logic [RATIO_W-1:0] ratio_q16 = RATIO_ONE;

  delay_report_t delay_reports_q[$];
  stim_row_t directed_rows[$];
  int err_cnt = 0;
  int burst_left = 0;
  int stall_cycles = 0;

  virtual_cpu_delay_tracker_unit #(
    .NS_PER_US(NS_PER_US_DEFAULT)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (func),
    .event_time_i   (evt_time),
    .delay_amount_i (delay_amt),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pending_delay_o(pending_delay),
    .blocked_o      (blocked)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scale by the ratio, truncate, then round to the precision step if set
  function automatic logic [63:0] scaled_delay(input logic [AMOUNT_W-1:0] amt);
    logic [63:0] val;
    logic [63:0] step;
    logic [63:0] rem;
    val = {32'b0, amt} * {32'b0, ratio_q16};
    val = val >> FRAC_W;
    if (prec_us != 0) begin
      step = 64'(prec_us) * NS_US;
      rem = val % step;
      val = val - rem;
      if (2 * rem >= step) begin
        val = val + step;
      end
    end
    return val;
  endfunction

  // advance the tracker by one word and work out its report
  task automatic track_word(input logic fn, input logic [TIME_W-1:0] t,
                            input logic [AMOUNT_W-1:0] amt,
                            output logic [TIME_W-1:0] pend, output logic blk);
    logic [63:0] add;
    logic [63:0] built;
    logic [63:0] thr_ns;
    if (fn == FN_TIME) begin
      cur_ns = {1'b0, t};
      if (free_ns < cur_ns) begin
        free_ns = cur_ns;
      end
    end else begin
      add = scaled_delay(amt);
      if (add > TIME_LIMIT - free_ns) begin
        free_ns = TIME_LIMIT;
      end else begin
        free_ns = free_ns + add;
      end
    end
    built = free_ns - cur_ns;
    thr_ns = 64'(thr_us) * NS_US;
    pend = '0;
    if (thr_us != 0 && built > thr_ns) begin
      pend = built[TIME_W-1:0];
    end
    blk = (pend != '0);
  endtask

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DAT_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t word_row(input logic fn, input logic [TIME_W-1:0] t,
                                         input logic [AMOUNT_W-1:0] amt);
    stim_row_t r;
    r = '0;
    r.fn = fn;
    r.evt = t;
    r.amt = amt;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic fn, input logic [TIME_W-1:0] t,
                                          input logic [AMOUNT_W-1:0] amt,
                                          input logic [TIME_W-1:0] pend,
                                          input logic blk);
    stim_row_t r;
    r = word_row(fn, t, amt);
    r.typed = 1'b1;
    r.want_pend = pend;
    r.want_blk = blk;
    return r;
  endfunction

  // register write, only issued while the block is idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_THRESHOLD:  thr_us = data[CFG_US_W-1:0];
      REG_PRECISION:  prec_us = data[CFG_US_W-1:0];
      REG_FREQ_RATIO: ratio_q16 = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offer one input word, predict its report on acceptance, then pace
  task automatic send_word(input stim_row_t r);
    delay_report_t rep;
    logic [TIME_W-1:0] pp;
    logic pb;
    @(negedge clk);
    in_valid <= 1'b1;
    func <= r.fn;
    evt_time <= r.evt;
    delay_amt <= r.amt;
    do @(posedge clk); while (!in_ready);
    track_word(r.fn, r.evt, r.amt, pp, pb);
    if (r.typed) begin
      pp = r.want_pend;
      pb = r.want_blk;
    end
    rep.pend = pp;
    rep.blk = pb;
    delay_reports_q.push_back(rep);
    // bursts of back-to-back words with random gaps in between
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                              : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  // let every outstanding report come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (delay_reports_q.size() != 0) @(negedge clk);
  endtask

  task automatic walk_rows(input int first, input int last);
    for (int i = first; i < last; i++) begin
      if (directed_rows[i].is_cfg) begin
        settle();
        cfg_write(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_word(directed_rows[i]);
      end
    end
  endtask

  // receiver stalls in stretches of differing character
  initial begin : rx_stall
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // check each result word against the oldest expected report
  always @(posedge clk) begin : report_check
    delay_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (delay_reports_q.size() == 0) begin
        report("unexpected result word, pending_delay", 64'(pending_delay), 64'd0);
      end else begin
        want = delay_reports_q.pop_front();
        if (pending_delay !== want.pend) begin
          report("pending_delay", 64'(pending_delay), 64'(want.pend));
        end
        if (blocked !== want.blk) begin
          report("blocked", 64'(blocked), 64'(want.blk));
        end
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int late_start;
    int k;
    logic [CFG_US_W-1:0] v16;
    logic [RATIO_W-1:0] v32;
    logic [63:0] rnd;
    logic [63:0] tv;
    logic [63:0] thr_ns;
    logic [63:0] d;
    stim_row_t r;

    // reset defaults: threshold off, so every report is zero
    directed_rows.push_back(known_row(FN_TIME, '0, '1, '0, 1'b0));
    directed_rows.push_back(known_row(FN_DELAY, '1, 32'd1000, '0, 1'b0));
    // one microsecond threshold, boundary on either side
    directed_rows.push_back(cfg_row(REG_THRESHOLD, 32'd1));
    directed_rows.push_back(known_row(FN_TIME, '0, '1, '0, 1'b0));
    directed_rows.push_back(known_row(FN_DELAY, '1, 32'd1, 63'd1001, 1'b1));
    // rounding to one microsecond, just below and at the half point
    directed_rows.push_back(cfg_row(REG_PRECISION, 32'hABCD_0001));
    directed_rows.push_back(word_row(FN_DELAY, '0, 32'd499));
    directed_rows.push_back(word_row(FN_DELAY, '0, 32'd500));
    directed_rows.push_back(word_row(FN_DELAY, '0, 32'd1499));
    // zero ratio, then half ratio with truncation
    directed_rows.push_back(cfg_row(REG_FREQ_RATIO, 32'd0));
    directed_rows.push_back(word_row(FN_DELAY, '1, '1));
    directed_rows.push_back(cfg_row(REG_FREQ_RATIO, 32'h0000_8000));
    directed_rows.push_back(cfg_row(REG_PRECISION, 32'd0));
    directed_rows.push_back(word_row(FN_DELAY, '0, 32'd3));
    // write to the unused index must change nothing
    directed_rows.push_back(cfg_row(REG_UNUSED, 32'hFFFF_FFFF));
    directed_rows.push_back(word_row(FN_TIME, 63'd5000, '1));
    directed_rows.push_back(word_row(FN_TIME, 63'd100, '0));
    // all registers at their top values
    directed_rows.push_back(cfg_row(REG_THRESHOLD, 32'h0000_FFFF));
    directed_rows.push_back(cfg_row(REG_PRECISION, 32'h0000_FFFF));
    directed_rows.push_back(cfg_row(REG_FREQ_RATIO, 32'hFFFF_FFFF));
    directed_rows.push_back(word_row(FN_DELAY, '0, '1));
    directed_rows.push_back(word_row(FN_DELAY, '1, '0));
    directed_rows.push_back(word_row(FN_TIME, 63'h2AAA_AAAA_AAAA_AAAA, 32'h5555_5555));
    directed_rows.push_back(word_row(FN_DELAY, 63'h5555_5555_5555_5555, 32'h5555_5555));
    // saturation pins free time at the top for good, so these rows run last
    late_start = directed_rows.size();
    directed_rows.push_back(cfg_row(REG_THRESHOLD, 32'h0000_FFFF));
    directed_rows.push_back(cfg_row(REG_PRECISION, 32'h0000_FFFF));
    directed_rows.push_back(cfg_row(REG_FREQ_RATIO, 32'hFFFF_FFFF));
    directed_rows.push_back(known_row(FN_TIME, TIME_MAX, '0, '0, 1'b0));
    directed_rows.push_back(known_row(FN_DELAY, '0, '1, '0, 1'b0));
    directed_rows.push_back(known_row(FN_TIME, '0, '1, TIME_MAX, 1'b1));
    directed_rows.push_back(known_row(FN_DELAY, '1, 32'd1, TIME_MAX, 1'b1));

    // reset
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    walk_rows(0, late_start);

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      k = $urandom_range(0, 7);
      case (k)
        0: v16 = '0;
        1: v16 = 16'd1;
        2: v16 = '1;
        default: v16 = 16'($urandom_range(1, 300));
      endcase
      cfg_write(REG_THRESHOLD, {16'($urandom), v16});
      k = $urandom_range(0, 7);
      case (k)
        0, 1, 2: v16 = '0;
        3: v16 = 16'd1;
        4: v16 = '1;
        default: v16 = 16'($urandom_range(1, 100));
      endcase
      cfg_write(REG_PRECISION, {16'($urandom), v16});
      k = $urandom_range(0, 7);
      case (k)
        0: v32 = RATIO_ONE;
        1: v32 = '0;
        2: v32 = '1;
        3: v32 = $urandom;
        default: v32 = $urandom_range(32'h0000_4000, 32'h0004_0000);
      endcase
      cfg_write(REG_FREQ_RATIO, v32);
      cfg_write(REG_UNUSED, $urandom);

      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        rnd = {$urandom, $urandom};
        r = word_row(FN_DELAY, rnd[TIME_W-1:0], $urandom);
        k = $urandom_range(0, 99);
        thr_ns = 64'(thr_us) * NS_US;
        if (k < 55) begin
          // delay word; event time is noise here
          case ($urandom_range(0, 3))
            0: r.amt = $urandom_range(0, 2000);
            1: r.amt = $urandom_range(0, 1 << 20);
            2: r.amt = $urandom;
            default: r.amt = 32'(64'(prec_us) * NS_US / 2) + $urandom_range(0, 2) - 1;
          endcase
        end else begin
          r.fn = FN_TIME;
          d = 64'($urandom_range(0, 200000));
          if (k < 70) begin
            // land the built delay on the threshold, one below or one above
            if (free_ns >= thr_ns + 1) begin
              tv = free_ns - thr_ns - 1 + $urandom_range(0, 2);
            end else begin
              tv = free_ns;
            end
          end else if (k < 85) begin
            tv = cur_ns + $urandom_range(0, 1 << 20);
          end else if (k < 93) begin
            // time going backward
            tv = (cur_ns > d) ? cur_ns - d : '0;
          end else begin
            tv = free_ns + d;
          end
          r.evt = tv[TIME_W-1:0];
        end
        send_word(r);
      end
    end

    walk_rows(late_start, directed_rows.size());

    settle();
    repeat (64) @(negedge clk);
    if (err_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/vcdt_pkg.sv
rtl/core/virtual_cpu_delay_tracker_unit.sv
test/testbench.sv
